// ===== design/hbcs_pkg.sv =====
// Shared types, codes and constants of the host bridge configuration space.
// No dependencies; the top, front and back design files import this package.
package hbcs_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] function_number;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        remap_valid;
        logic [19:0] region_base;
        logic        region_is_64k;
        logic        read_internal;
        logic        write_internal;
        logic        shadow_bios;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        MODE_READ      = 2'd0,
        MODE_WRITE     = 2'd1,
        MODE_BUS_RESET = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_READ,
        CMD_READ_FF,
        CMD_WRITE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] addr;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_EMIT
    } t_back_state;

    localparam logic [7:0] ADDR_CMD_LO  = 8'h04;
    localparam logic [7:0] ADDR_CMD_HI  = 8'h05;
    localparam logic [7:0] ADDR_STS_LO  = 8'h06;
    localparam logic [7:0] ADDR_STS_HI  = 8'h07;
    localparam logic [7:0] ADDR_RO_LO   = 8'h10;
    localparam logic [7:0] ADDR_RO_HI   = 8'h4E;
    localparam logic [7:0] ADDR_PAM0    = 8'h59;
    localparam logic [7:0] ADDR_PAM1    = 8'h5A;
    localparam logic [7:0] ADDR_PAM6    = 8'h5F;

    localparam logic [7:0] CMD_WR_MASK  = 8'h02;
    localparam logic [7:0] CMD_FORCE    = 8'h04;
    localparam logic [7:0] STS_WR_MASK  = 8'h80;
    localparam logic [7:0] STS_FORCE    = 8'h02;
    localparam logic [7:0] NO_FUNC_DATA = 8'hFF;

    localparam logic [19:0] BIOS_BASE   = 20'hF0000;
    localparam logic [19:0] OPTROM_BASE = 20'hC0000;
    localparam logic [19:0] HALF_STEP   = 20'h04000;

    // Power-on contents of the register file.
    function automatic logic [7:0] reset_byte(input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        case (addr)
            8'h00: v = 8'h86;
            8'h01: v = 8'h80;
            8'h02: v = 8'h50;
            8'h03: v = 8'h12;
            8'h04: v = 8'h06;
            8'h07: v = 8'h02;
            8'h0B: v = 8'h06;
            8'h51: v = 8'h20;
            8'h52: v = 8'hB5;
            8'h56: v = 8'h52;
            8'h57: v = 8'h01;
            8'h59: v = 8'h40;
            8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F: v = 8'h44;
            8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67: v = 8'h02;
            8'h68: v = 8'h11;
            8'h72: v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== design/host_bridge_config_space_pam.sv =====
// Host bridge PCI configuration space with PAM shadow control. Each access
// word (read, write or bus reset) yields one result word, or one per changed
// PAM nibble (at most two), the final one flagged by last. An access goes
// through the execute unit as compare and write-back, then result push, which
// overlaps the register file read of the next access; an extra result or a
// full result queue holds it in the push step. From idle the register file
// read comes first. The 256x8 register file has one read and one write port.
// Untouched bytes read their power-on value through per-byte valid flags, so
// no clearing pass runs after reset.
module host_bridge_config_space_pam #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  hbcs_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output hbcs_pkg::t_out_item o_out_item
);
    import hbcs_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);

    t_cmd      front_cmd, cmd_head;
    logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_out_item res_word;
    logic      res_push, res_full;

    hbcs_front u_front (
        .push       (push),
        .full       (full),
        .i_item     (i_in_item),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (front_cmd)
    );

    hbcs_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    hbcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_word)
    );

    hbcs_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_big_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.remap_valid) |->
            (o_out_item.region_is_64k == (o_out_item.region_base == BIOS_BASE)))
        else $error("64K flag disagrees with region base");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.remap_valid) |->
            (o_out_item.region_base == 20'd0 && !o_out_item.region_is_64k
             && o_out_item.last))
        else $error("non-remap result carries region fields");

endmodule

// ===== design/hbcs_fifo.sv =====
// Small synchronous FIFO, first-word fall-through, used for the command and
// result queues. Depends on nothing.
module hbcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= bump(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== design/hbcs_front.sv =====
// Front end: accepts access words and turns them into register file commands
// (function check, write protection, command/status masking). Uses hbcs_pkg.
module hbcs_front (
    input  logic              push,
    output logic              full,
    input  hbcs_pkg::t_in_item i_item,
    output logic              o_cmd_push,
    input  logic              i_cmd_full,
    output hbcs_pkg::t_cmd    o_cmd
);
    import hbcs_pkg::*;

    logic [7:0] addr, d;
    logic       prot;

    assign addr = i_item.reg_addr;
    assign d    = i_item.write_data;
    assign full       = i_cmd_full;
    assign o_cmd_push = push && !i_cmd_full;

    always_comb begin
        prot = (addr >= ADDR_RO_LO && addr <= ADDR_RO_HI);
        case (addr)
            8'h00, 8'h01, 8'h02, 8'h03,
            8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0E: prot = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        o_cmd.kind = CMD_NOP;
        o_cmd.addr = addr;
        o_cmd.data = d;
        case (t_mode'(i_item.mode))
            MODE_READ: begin
                o_cmd.kind = (i_item.function_number != 3'd0) ? CMD_READ_FF : CMD_READ;
            end
            MODE_WRITE: begin
                if (i_item.function_number == 3'd0 && !prot) begin
                    o_cmd.kind = CMD_WRITE;
                    case (addr)
                        ADDR_CMD_LO: o_cmd.data = (d & CMD_WR_MASK) | CMD_FORCE;
                        ADDR_CMD_HI, ADDR_STS_LO: o_cmd.data = 8'h00;
                        ADDR_STS_HI: o_cmd.data = (d & STS_WR_MASK) | STS_FORCE;
                        default: o_cmd.data = d;
                    endcase
                end
            end
            MODE_BUS_RESET: begin
                // bus reset clears PAM0 like a function 0 write
                o_cmd.kind = CMD_WRITE;
                o_cmd.addr = ADDR_PAM0;
                o_cmd.data = 8'h00;
            end
            default: o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== design/hbcs_back.sv =====
// Back end: owns the 256-byte register file and shadow flag, runs one
// command at a time and builds the result words. Uses hbcs_pkg.
module hbcs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  hbcs_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output hbcs_pkg::t_out_item o_res
);
    import hbcs_pkg::*;

    t_back_state r_state, n_state;
    logic [7:0]  r_mem [256];
    logic [255:0] r_valid;
    logic [7:0]  r_rd_data, r_rd_init;
    logic        r_rd_valid;
    t_cmd        r_cmd;
    logic        r_shadow, n_shadow;
    t_out_item   r_res0, r_res1, n_res0, n_res1;
    logic        r_two, n_two;
    logic        r_emit_idx;
    logic        last_push;

    logic [7:0]  old, diff;
    logic        pam0, pam16, lo_chg, hi_chg;
    logic [2:0]  pam_idx;
    logic [19:0] base_lo;
    t_out_item   lo_res, hi_res, plain_res;

    assign last_push = !i_res_full && (r_emit_idx == r_two);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_cmd_empty) n_state = BK_EXEC;
            BK_EXEC: n_state = BK_EMIT;
            BK_EMIT: if (last_push) n_state = i_cmd_empty ? BK_IDLE : BK_EXEC;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            BK_IDLE: o_cmd_pop = !i_cmd_empty;
            BK_EMIT: begin
                o_res_push = !i_res_full;
                o_cmd_pop  = last_push && !i_cmd_empty;
            end
            default: ;
        endcase
    end

    assign o_res = r_emit_idx ? r_res1 : r_res0;

    // result words for the command held in r_cmd
    always_comb begin
        old     = r_rd_valid ? r_rd_data : r_rd_init;
        diff    = old ^ r_cmd.data;
        pam0    = (r_cmd.kind == CMD_WRITE) && (r_cmd.addr == ADDR_PAM0);
        pam16   = (r_cmd.kind == CMD_WRITE) && (r_cmd.addr >= ADDR_PAM1)
                  && (r_cmd.addr <= ADDR_PAM6);
        lo_chg  = pam16 && (diff[3:0] != 4'd0);
        hi_chg  = (pam0 || pam16) && (diff[7:4] != 4'd0);
        pam_idx = r_cmd.addr[2:0] - 3'd2;
        base_lo = OPTROM_BASE + {2'b00, pam_idx, 15'd0};

        n_shadow = r_shadow;
        if (pam0 && hi_chg) n_shadow = r_cmd.data[4];

        lo_res                = '0;
        lo_res.remap_valid    = 1'b1;
        lo_res.region_base    = base_lo;
        lo_res.read_internal  = r_cmd.data[0];
        lo_res.write_internal = r_cmd.data[1];
        lo_res.shadow_bios    = n_shadow;

        hi_res                = '0;
        hi_res.remap_valid    = 1'b1;
        hi_res.region_base    = pam0 ? BIOS_BASE : base_lo + HALF_STEP;
        hi_res.region_is_64k  = pam0;
        hi_res.read_internal  = r_cmd.data[4];
        hi_res.write_internal = r_cmd.data[5];
        hi_res.shadow_bios    = n_shadow;

        plain_res             = '0;
        plain_res.shadow_bios = n_shadow;
        plain_res.last        = 1'b1;
        case (r_cmd.kind)
            CMD_READ:    plain_res.read_data = old;
            CMD_READ_FF: plain_res.read_data = NO_FUNC_DATA;
            default:     plain_res.read_data = 8'h00;
        endcase

        n_two  = 1'b0;
        n_res1 = hi_res;
        n_res1.last = 1'b1;
        if (lo_chg) begin
            n_res0 = lo_res;
            n_two  = hi_chg;
            n_res0.last = !hi_chg;
        end else if (hi_chg) begin
            n_res0 = hi_res;
            n_res0.last = 1'b1;
        end else begin
            n_res0 = plain_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_valid    <= '0;
            r_shadow   <= 1'b0;
            r_emit_idx <= 1'b0;
            r_two      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_EXEC) begin
                r_shadow   <= n_shadow;
                r_two      <= n_two;
                r_emit_idx <= 1'b0;
                if (r_cmd.kind == CMD_WRITE) r_valid[r_cmd.addr] <= 1'b1;
            end else if (r_state == BK_EMIT && o_res_push && !last_push) begin
                r_emit_idx <= 1'b1;
            end
        end
    end

    // register file: read on command pop, write on execute
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd      <= i_cmd;
            r_rd_data  <= r_mem[i_cmd.addr];
            r_rd_valid <= r_valid[i_cmd.addr];
            r_rd_init  <= reset_byte(i_cmd.addr);
        end
        if (r_state == BK_EXEC) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
            if (r_cmd.kind == CMD_WRITE) r_mem[r_cmd.addr] <= r_cmd.data;
        end
    end

endmodule

// ===== verif/tb_host_bridge_config_space_pam.sv =====
// Self-checking testbench for the host bridge configuration space with PAM remap words.
// Depends on hbcs_pkg and host_bridge_config_space_pam; runs a directed table, then random
// words under several idle/stall mixes; checks each result against a row or a predictor.
module tb_host_bridge_config_space_pam;
    timeunit 1ns;
    timeprecision 1ps;
    import hbcs_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 60;

    // Bytes outside the package constants that never take a write
    localparam logic [7:0] ADDR_ID_LAST  = 8'h03;
    localparam logic [7:0] ADDR_CLASS_LO = 8'h08;
    localparam logic [7:0] ADDR_CLASS_HI = 8'h0C;
    localparam logic [7:0] ADDR_BIST_LO  = 8'h0E;

    typedef struct {
        t_in_item  word;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    logic [7:0] cfg_mirror [256];
    logic       shadow_mirror;
    t_out_item  expected_words [$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_request   = 1'b0;

    host_bridge_config_space_pam u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item remap_word(input logic [19:0] base, input logic big,
                                             input logic [1:0] rw);
        t_out_item r;
        r = '0;
        r.remap_valid    = 1'b1;
        r.region_base    = base;
        r.region_is_64k  = big;
        r.read_internal  = rw[0];
        r.write_internal = rw[1];
        return r;
    endfunction

    // Updates the register mirror and queues the result words one access produces.
    function automatic void predict_access(input t_in_item w);
        t_out_item   res [$];
        t_out_item   r;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  old;
        logic [19:0] base;
        bit          do_write;
        do_write = 1'b0;
        a = w.reg_addr;
        v = w.write_data;
        case (w.mode)
            MODE_READ: begin
                r = '0;
                r.read_data = (w.function_number != 3'd0) ? NO_FUNC_DATA : cfg_mirror[a];
                res.push_back(r);
            end
            MODE_WRITE: do_write = (w.function_number == 3'd0);
            MODE_BUS_RESET: begin
                do_write = 1'b1;
                a = ADDR_PAM0;
                v = 8'h00;
            end
            default: ;
        endcase
        if (a <= ADDR_ID_LAST || (a >= ADDR_CLASS_LO && a <= ADDR_CLASS_HI) ||
            a == ADDR_BIST_LO || (a >= ADDR_RO_LO && a <= ADDR_RO_HI)) begin
            do_write = 1'b0;
        end
        if (do_write) begin
            old = cfg_mirror[a];
            case (a)
                ADDR_CMD_LO: v = (v & CMD_WR_MASK) | CMD_FORCE;
                ADDR_CMD_HI, ADDR_STS_LO: v = 8'h00;
                ADDR_STS_HI: v = (v & STS_WR_MASK) | STS_FORCE;
                ADDR_PAM0: begin
                    if (old[7:4] != v[7:4]) begin
                        shadow_mirror = v[4];
                        res.push_back(remap_word(BIOS_BASE, 1'b1, v[5:4]));
                    end
                end
                default: begin
                    if (a >= ADDR_PAM1 && a <= ADDR_PAM6) begin
                        // each PAM byte covers two 16K regions, low nibble first
                        base = OPTROM_BASE + 20'(a - ADDR_PAM1) * (HALF_STEP << 1);
                        if (old[3:0] != v[3:0])
                            res.push_back(remap_word(base, 1'b0, v[1:0]));
                        if (old[7:4] != v[7:4])
                            res.push_back(remap_word(base + HALF_STEP, 1'b0, v[5:4]));
                    end
                end
            endcase
            cfg_mirror[a] = v;
        end
        if (res.size() == 0)
            res.push_back('0);
        foreach (res[i])
            res[i].shadow_bios = shadow_mirror;
        res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_words.push_back(res[i]);
    endfunction

    function automatic void cmp_field(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_word(input t_out_item got);
        t_out_item want;
        if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result word with nothing expected: expected none, actual %h",
                         $time, got);
            return;
        end
        want = expected_words.pop_front();
        cmp_field("read_data", 20'(want.read_data), 20'(got.read_data));
        cmp_field("remap_valid", 20'(want.remap_valid), 20'(got.remap_valid));
        cmp_field("region_base", want.region_base, got.region_base);
        cmp_field("region_is_64k", 20'(want.region_is_64k), 20'(got.region_is_64k));
        cmp_field("read_internal", 20'(want.read_internal), 20'(got.read_internal));
        cmp_field("write_internal", 20'(want.write_internal), 20'(got.write_internal));
        cmp_field("shadow_bios", 20'(want.shadow_bios), 20'(got.shadow_bios));
        cmp_field("last", 20'(want.last), 20'(got.last));
    endfunction

    function automatic t_directed_row stim_row(input t_mode m, input logic [2:0] fn,
                                               input logic [7:0] a, input logic [7:0] d,
                                               input bit typed = 1'b0,
                                               input logic [7:0] rd = 8'h00);
        t_directed_row row_v;
        row_v.word.mode            = m;
        row_v.word.function_number = fn;
        row_v.word.reg_addr        = a;
        row_v.word.write_data      = d;
        row_v.typed                = typed;
        row_v.result               = '0;
        row_v.result.read_data     = rd;
        row_v.result.last          = 1'b1;
        return row_v;
    endfunction

    // PAM writes for 40 percent of words so remaps keep happening; the rest spans the whole space.
    function automatic t_in_item random_word();
        t_in_item w;
        int       pick;
        w.mode            = MODE_WRITE;
        w.function_number = 3'd0;
        w.reg_addr        = 8'($urandom_range(255));
        w.write_data      = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 40) begin
            w.reg_addr = 8'($urandom_range(ADDR_PAM6, ADDR_PAM0));
            // keep one nibble now and then so single-remap words show up
            if ($urandom_range(3) == 0)
                w.write_data[7:4] = cfg_mirror[w.reg_addr][7:4];
            else if ($urandom_range(3) == 0)
                w.write_data[3:0] = cfg_mirror[w.reg_addr][3:0];
        end else if (pick < 70) begin
            w.mode = MODE_READ;
            if (pick < 55)
                w.reg_addr = 8'($urandom_range(ADDR_PAM6));
        end else if (pick < 82) begin
            w.mode = MODE_WRITE;
        end else if (pick < 88) begin
            w.reg_addr = 8'($urandom_range(ADDR_STS_HI, ADDR_CMD_LO));
        end else if (pick < 96) begin
            w.mode = MODE_BUS_RESET;
        end else begin
            w.mode = MODE_UNUSED;
        end
        if ($urandom_range(9) == 0)
            w.function_number = 3'($urandom_range(7, 1));
        return w;
    endfunction

    task automatic send_word(input t_in_item w, input bit typed, input t_out_item result);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= w;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (typed)
            expected_words.push_back(result);
        else
            predict_access(w);
    endtask

    // Result side: checks accepted words and decides pop for the next edge.
    initial begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                check_word(o_out_item);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        t_directed_row directed_rows [$];
        int            drain_wait;
        i_rst_n   = 1'b0;
        push      = 1'b0;
        i_in_item = '0;

        for (int i = 0; i < 256; i++)
            cfg_mirror[8'(i)] = 8'h00;
        cfg_mirror[8'h00] = 8'h86;
        cfg_mirror[8'h01] = 8'h80;
        cfg_mirror[8'h02] = 8'h50;
        cfg_mirror[8'h03] = 8'h12;
        cfg_mirror[8'h04] = 8'h06;
        cfg_mirror[8'h07] = 8'h02;
        cfg_mirror[8'h0B] = 8'h06;
        cfg_mirror[8'h51] = 8'h20;
        cfg_mirror[8'h52] = 8'hB5;
        cfg_mirror[8'h56] = 8'h52;
        cfg_mirror[8'h57] = 8'h01;
        cfg_mirror[8'h59] = 8'h40;
        for (int i = 8'h5A; i <= 8'h5F; i++)
            cfg_mirror[8'(i)] = 8'h44;
        for (int i = 8'h60; i <= 8'h67; i++)
            cfg_mirror[8'(i)] = 8'h02;
        cfg_mirror[8'h68] = 8'h11;
        cfg_mirror[8'h72] = 8'h02;
        shadow_mirror = 1'b0;

        // Typed rows: power-on values, missing function, dropped writes, unused mode
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, 8'h00, 8'h00, 1'b1, 8'h86));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_ID_LAST, 8'h00, 1'b1, 8'h12));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_PAM0, 8'h00, 1'b1, 8'h40));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, 8'hFF, 8'hFF, 1'b1, 8'h00));
        directed_rows.push_back(stim_row(MODE_READ, 3'd7, 8'h00, 8'h00, 1'b1, NO_FUNC_DATA));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd4, ADDR_PAM0, 8'hFF, 1'b1));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, 8'h00, 8'hFF, 1'b1));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_RO_HI, 8'hAA, 1'b1));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_RO_LO, 8'h55, 1'b1));
        directed_rows.push_back(stim_row(MODE_UNUSED, 3'd7, 8'hFF, 8'hFF, 1'b1));
        // Predicted rows
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_RO_HI + 8'd1, 8'hFF));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_RO_HI + 8'd1, 8'h00));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_CMD_LO, 8'hFF));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_CMD_LO, 8'h00));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_STS_HI, 8'hFF));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_STS_HI, 8'h00));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_STS_LO, 8'hFF));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM0, 8'h30));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM1, 8'h33));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM6, 8'h00));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM1 + 8'd2, 8'h44));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM1 + 8'd3, 8'h4C));
        directed_rows.push_back(stim_row(MODE_BUS_RESET, 3'd5, 8'h12, 8'hFF));
        directed_rows.push_back(stim_row(MODE_BUS_RESET, 3'd0, 8'h00, 8'h00));
        directed_rows.push_back(stim_row(MODE_WRITE, 3'd0, ADDR_PAM0, 8'h0F));
        directed_rows.push_back(stim_row(MODE_READ, 3'd0, ADDR_PAM0, 8'h00));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // receiver holds off while words keep coming, so full must rise
                    hold_request   = 1'b1;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
                send_word(random_word(), 1'b0, '0);
        end
        push <= 1'b0;

        drain_wait = 0;
        while (expected_words.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            mismatch_count++;
            $display("%0t: result words still owed: expected 0, actual %0d", $time,
                     expected_words.size());
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hbcs_pkg.sv
design/hbcs_fifo.sv
design/hbcs_front.sv
design/hbcs_back.sv
design/host_bridge_config_space_pam.sv
verif/tb_host_bridge_config_space_pam.sv
